// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset
`define SLP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/slp_pkg.sv =====
`default_nettype none
package slp_pkg;
  localparam int GRID_MAX = 1024;
  localparam int AW       = $clog2(GRID_MAX);
  localparam int HW       = 11;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  // Skyline store access
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [HW-1:0] wdata;
    logic [AW-1:0] raddr;
  } slp_mem_req_t;

  // One placement result
  typedef struct packed {
    logic          placed;
    logic [9:0]    pos_x;
    logic [HW-1:0] pos_y;
    logic [HW-1:0] top;
  } slp_res_t;
endpackage
`default_nettype wire

// ===== rtl/slp_sky_ram.sv =====
`default_nettype none
module slp_sky_ram
  import slp_pkg::*;
(
  input  wire logic         clk,
  input  wire slp_mem_req_t req,
  output logic [HW-1:0]     rdata
);
  logic [HW-1:0] mem [GRID_MAX];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/slp_seq.sv =====
`default_nettype none
`include "assert_macros.svh"
module slp_seq
  import slp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [10:0]   cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_cmd,
  input  wire logic [10:0]   in_w,
  input  wire logic [10:0]   in_h,
  output logic               res_valid,
  input  wire logic          res_ready,
  output slp_res_t           res,
  output slp_mem_req_t       mem_req,
  input  wire logic [HW-1:0] mem_rdata
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_SCAN, S_ACC, S_DONE, S_WRITE} state_t;

  state_t        state_r, state_nxt;
  logic [10:0]   cfg_grid_r;
  logic [10:0]   grid_r, grid_nxt;
  logic [10:0]   w_r, w_nxt, h_r, h_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [10:0]   off_r, off_nxt;
  logic [HW-1:0] ymax_r, ymax_nxt;
  logic [9:0]    bx_r, bx_nxt;
  logic [HW-1:0] by_r, by_nxt;
  logic [11:0]   btop_r, btop_nxt;
  logic          found_r, found_nxt;

  logic [10:0]   grid_eff;
  logic [10:0]   rd_sum, wr_sum, start_inc;
  logic [11:0]   cand_top;
  logic [12:0]   next_end;

  assign grid_eff  = (cfg_grid_r > 11'(GRID_MAX)) ? 11'(GRID_MAX) : cfg_grid_r;
  assign rd_sum    = {1'b0, start_r} + off_r;
  assign wr_sum    = {1'b0, bx_r} + off_r;
  assign cand_top  = {1'b0, ymax_r} + {1'b0, h_r};
  assign start_inc = {1'b0, start_r} + 11'd1;
  assign next_end  = {2'b0, start_inc} + {2'b0, w_r};

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.placed = found_r;
  assign res.pos_x  = bx_r;
  assign res.pos_y  = by_r;
  assign res.top    = found_r ? btop_r[HW-1:0] : '0;

  // Store access
  always_comb begin
    mem_req.raddr = rd_sum[AW-1:0];
    mem_req.we    = 1'b0;
    mem_req.waddr = clr_r;
    mem_req.wdata = '0;
    if (state_r == S_CLR) begin
      mem_req.we = 1'b1;
    end else if (state_r == S_WRITE) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = wr_sum[AW-1:0];
      mem_req.wdata = btop_r[HW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    grid_nxt  = grid_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    clr_nxt   = clr_r;
    start_nxt = start_r;
    off_nxt   = off_r;
    ymax_nxt  = ymax_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    btop_nxt  = btop_r;
    found_nxt = found_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(GRID_MAX - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_CLEAR) begin
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end else begin
            grid_nxt  = grid_eff;
            w_nxt     = in_w;
            h_nxt     = in_h;
            start_nxt = '0;
            off_nxt   = '0;
            ymax_nxt  = '0;
            bx_nxt    = '0;
            by_nxt    = '0;
            btop_nxt  = {1'b0, grid_eff} + 12'd1;
            found_nxt = 1'b0;
            if (grid_eff == '0 || in_w > grid_eff) state_nxt = S_DONE;
            else state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (off_r == w_r) begin
          // span finished: compare its top with the best so far
          if (cand_top < btop_r) begin
            btop_nxt  = cand_top;
            bx_nxt    = start_r;
            by_nxt    = ymax_r;
            found_nxt = 1'b1;
          end
          off_nxt  = '0;
          ymax_nxt = '0;
          // next start must lie inside the grid and its span must fit
          if (next_end <= {2'b0, grid_r} && start_inc < grid_r) begin
            start_nxt = start_inc[AW-1:0];
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (mem_rdata > ymax_r) ymax_nxt = mem_rdata;
        off_nxt   = off_r + 11'd1;
        state_nxt = S_SCAN;
      end
      S_DONE: begin
        if (res_ready) begin
          off_nxt = '0;
          if (found_r && w_r != '0) state_nxt = S_WRITE;
          else state_nxt = S_IDLE;
        end
      end
      S_WRITE: begin
        off_nxt = off_r + 11'd1;
        if (off_r + 11'd1 == w_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      cfg_grid_r <= 11'(GRID_MAX);
      found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      found_r <= found_nxt;
      if (cfg_we) cfg_grid_r <= cfg_wdata;
    end
    grid_r  <= grid_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    start_r <= start_nxt;
    off_r   <= off_nxt;
    ymax_r  <= ymax_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    btop_r  <= btop_nxt;
  end

  `SLP_ASSERT_IMP(a_top_sum, clk, rst_n, res_valid && res.placed, res.top == res.pos_y + h_r, "placed top is not bottom plus height")
  `SLP_ASSERT_IMP(a_rd_in_grid, clk, rst_n, state_r == S_ACC, $past(rd_sum) < grid_r, "read outside the grid")
  `SLP_ASSERT_NEVER(a_res_in_clr, clk, rst_n, res_valid && (state_r == S_CLR), "result during clear")
endmodule
`default_nettype wire

// ===== rtl/skyline_rectangle_placer_unit.sv =====
// Skyline rectangle placer: keeps one height per column of a square grid
// (grid size from cfg_wdata, capped at 1024) in a 1024 x 11 single-port-write
// RAM. A clear transaction (tuser 0) zeroes the store and gives no result;
// the same sweep runs after reset, with in_tready low. A place transaction
// scans every start column whose span fits in the grid, reading each spanned
// column through the one RAM read port, then writes the new top back over
// the span on success. One transaction is processed at a time; a finished
// result waits in the output register.
`default_nettype none
module skyline_rectangle_placer_unit
  import slp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // rect_width[10:0], rect_height[21:11], zero
  input  wire logic        in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // pos_x[9:0], pos_y[20:10], top_height[31:21]
  output logic             out_tuser   // placed
);
  slp_mem_req_t  mem_req;
  logic [HW-1:0] mem_rdata;
  logic          res_valid, res_ready;
  slp_res_t      res;
  logic          out_valid_r;
  slp_res_t      out_r;

  slp_sky_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  slp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_w      (in_tdata[10:0]),
    .in_h      (in_tdata[21:11]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // Output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.placed;
  assign out_tdata  = {out_r.top, out_r.pos_y, out_r.pos_x};
endmodule
`default_nettype wire

// ===== dv/tb_skyline_rectangle_placer_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_skyline_rectangle_placer_unit;
  import slp_pkg::*;

  localparam int SETTLE_CYC = 1200;     // clear sweep or write-back still running
  localparam int LIMIT_CYC  = 4000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // rect_width[10:0], rect_height[21:11], zero
  logic        in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // pos_x[9:0], pos_y[20:10], top_height[31:21]
  logic        out_tuser;  // placed

  skyline_rectangle_placer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Skyline packer prediction and placement checking
  class placement_board;
    int unsigned heights[GRID_MAX];
    int unsigned grid_cfg;
    slp_res_t    placements[$];
    int          errors;
    int          n_clears;
    int          n_placed;
    int          n_rejected;

    function new();
      grid_cfg = 1024;
      foreach (heights[i]) heights[i] = 0;
    endfunction

    function void set_grid(logic [10:0] v);
      grid_cfg = v;
    endfunction

    // Accepted transaction: update the skyline and queue the placement
    function void note_request(logic cmd, logic [10:0] w, logic [10:0] h);
      int unsigned g, best_top, best_x, best_y, y;
      bit          found;
      slp_res_t    r;
      if (cmd == CMD_CLEAR) begin
        foreach (heights[i]) heights[i] = 0;
        n_clears++;
        return;
      end
      g = (grid_cfg > GRID_MAX) ? GRID_MAX : grid_cfg;
      best_top = g + 1;
      best_x = 0;
      best_y = 0;
      found = 0;
      for (int unsigned i = 0; i < g && i + w <= g; i++) begin
        y = 0;
        for (int unsigned j = 0; j < w; j++)
          if (heights[i + j] > y) y = heights[i + j];
        if (y + h < best_top) begin
          best_top = y + h;
          best_x = i;
          best_y = y;
          found = 1;
        end
      end
      r = '0;
      if (found) begin
        for (int unsigned j = 0; j < w; j++) heights[best_x + j] = best_top;
        r.placed = 1'b1;
        r.pos_x  = best_x[9:0];
        r.pos_y  = best_y[10:0];
        r.top    = best_top[10:0];
      end
      placements = {placements, r};
    endfunction

    task report(string what, int got, int want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic placed, logic [9:0] x, logic [10:0] y, logic [10:0] top);
      slp_res_t e;
      if (placements.size() == 0) begin
        report("unexpected placement transaction", placed, 0);
        return;
      end
      e = placements.pop_front();
      if (e.placed) n_placed++; else n_rejected++;
      if (placed !== e.placed) report("placed", placed, e.placed);
      if (x !== e.pos_x) report("pos_x", x, e.pos_x);
      if (y !== e.pos_y) report("pos_y", y, e.pos_y);
      if (top !== e.top) report("top_height", top, e.top);
    endtask
  endclass

  placement_board board;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int unsigned cycles;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tuser, out_tdata[9:0], out_tdata[20:10], out_tdata[31:21]);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task send_request(logic cmd, logic [10:0] w, logic [10:0] h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, h, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(cmd, w, h);
  endtask

  // Drain, let the block go quiet, then write the grid size
  task write_grid(logic [10:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_grid(v);
  endtask

  // Mostly well-formed packing runs, some clears and noise
  task random_run(int n, int g);
    int          r;
    logic [10:0] w, h;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_request(CMD_CLEAR, 11'($urandom), 11'($urandom));
      end else if (r < 85) begin
        w = 11'($urandom_range(g / 3 + 1, 1));
        h = 11'($urandom_range(g / 4 + 1, 0));
        send_request(CMD_PLACE, w, h);
      end else begin
        w = (r < 92) ? 11'($urandom_range(g + 1)) : 11'($urandom);
        h = 11'($urandom);
        send_request(CMD_PLACE, w, h);
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_CLEAR;
    out_tready = 1'b0;
    hold_left = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full grid at reset size
    send_request(CMD_PLACE, 11'd1024, 11'd5);
    send_request(CMD_PLACE, 11'd1, 11'd1019);
    send_request(CMD_PLACE, 11'd1, 11'd1019);
    send_request(CMD_PLACE, 11'd0, 11'd0);
    send_request(CMD_PLACE, 11'd0, 11'd1024);
    send_request(CMD_PLACE, 11'd2047, 11'd1);
    send_request(CMD_PLACE, 11'd1, 11'd2047);
    send_request(CMD_PLACE, 11'd3, 11'd0);
    send_request(CMD_CLEAR, 11'd2047, 11'd2047);
    send_request(CMD_PLACE, 11'd1, 11'd1024);
    // Zero grid: nothing fits
    write_grid(11'd0);
    send_request(CMD_PLACE, 11'd0, 11'd0);
    send_request(CMD_PLACE, 11'd1, 11'd1);
    // One-column grid, heights kept from before
    write_grid(11'd1);
    send_request(CMD_PLACE, 11'd1, 11'd0);
    send_request(CMD_PLACE, 11'd2, 11'd0);
    send_request(CMD_CLEAR, 11'd0, 11'd0);
    send_request(CMD_PLACE, 11'd1, 11'd1);
    send_request(CMD_PLACE, 11'd1, 11'd0);
    send_request(CMD_PLACE, 11'd0, 11'd1);
    // Small grid: ties and a top exactly at the grid
    write_grid(11'd6);
    send_request(CMD_CLEAR, 11'd0, 11'd0);
    send_request(CMD_PLACE, 11'd2, 11'd3);
    send_request(CMD_PLACE, 11'd2, 11'd3);
    send_request(CMD_PLACE, 11'd2, 11'd3);
    send_request(CMD_PLACE, 11'd6, 11'd0);
    send_request(CMD_PLACE, 11'd1, 11'd3);

    // Random, sender 27 / receiver 62
    write_grid(11'd64);
    send_request(CMD_CLEAR, 11'd0, 11'd0);
    send_idle_pct = 27;
    recv_idle_pct = 62;
    random_run(87, 64);

    // Random, sender 62 / receiver 27
    write_grid(11'd17);
    send_idle_pct = 62;
    recv_idle_pct = 27;
    random_run(87, 17);

    // No idling; a long receiver hold-off first to back up the input
    write_grid(11'd40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 3000;
    random_run(87, 40);

    // Oversized register value, capped at the store depth
    write_grid(11'd2047);
    send_request(CMD_CLEAR, 11'd0, 11'd0);
    send_request(CMD_PLACE, 11'd1, 11'd1024);
    send_request(CMD_PLACE, 11'd1024, 11'd1);
    send_request(CMD_PLACE, 11'd1025, 11'd1);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (board.placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    $display("covered %0d clears, %0d placements and %0d rejections",
             board.n_clears, board.n_placed, board.n_rejected);
    $display("grid sizes 0, 1, 6, 17, 40, 64, 1024 and capped 2047, with stalls on both sides");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/slp_pkg.sv
rtl/slp_sky_ram.sv
rtl/slp_seq.sv
rtl/skyline_rectangle_placer_unit.sv
dv/tb_skyline_rectangle_placer_unit.sv
